// ===== hdl/pim_pkg.sv =====
`default_nettype none
package pim_pkg;

  localparam int unsigned WAIT_DEPTH_DEF    = 16;
  localparam int unsigned TASK_ID_BITS_DEF  = 8;
  localparam int unsigned PRIORITY_BITS_DEF = 5;

  localparam int unsigned STATUS_W = 3;

  localparam logic CMD_TAKE = 1'b0;
  localparam logic CMD_GIVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_BLOCKED   = 3'd2,
    ST_WAIT_FULL = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_FREED     = 3'd5,
    ST_HANDOVER  = 3'd6
  } status_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } pim_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/priority_inheritance_mutex.sv =====
// Priority-inheritance mutex with a FIFO of waiting tasks. Each input transaction is a take
// (tuser 0) or a give (tuser 1) from one task, and each yields exactly one output transaction
// whose tuser carries the status code. A transaction passes an accept step, which captures it and
// starts the read of the waiter FIFO head, and then a decide step, which updates the lock, since the
// waiter store is a RAM with a registered read port. A new transaction is accepted while the
// previous result waits in the output register; the decision cycle holds only while that
// register is still occupied. No clearing pass is needed after reset.
`default_nettype none
module priority_inheritance_mutex #(
  parameter int unsigned WAIT_DEPTH    = pim_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS  = pim_pkg::TASK_ID_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = pim_pkg::PRIORITY_BITS_DEF,
  localparam int unsigned IN_W  = ((TASK_ID_BITS + PRIORITY_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * PRIORITY_BITS + 2 * TASK_ID_BITS + 4 + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: task_id, task_priority, owner_in_ready, zero fill.
  input  wire logic [IN_W-1:0]              s_axis_tdata,
  // Fields from bit 0: cmd.
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // Fields from bit 0: boost_owner, boosted_task, boosted_priority, move_owner_ready,
  // giver_priority, next_owner, next_owner_priority, requeue_giver, request_switch, zero fill.
  output logic      [OUT_W-1:0]             m_axis_tdata,
  // Fields from bit 0: status.
  output logic      [pim_pkg::STATUS_W-1:0] m_axis_tuser
);

  pim_pkg::pim_cmd_t cmd;

  pim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  pim_datapath #(
    .WAIT_DEPTH   (WAIT_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .IN_W         (IN_W),
    .OUT_W        (OUT_W)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_user_i (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .out_user_o(m_axis_tuser),
    .out_data_o(m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/pim_ram.sv =====
`default_nettype none
module pim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/pim_datapath.sv =====
`default_nettype none
module pim_datapath #(
  parameter int unsigned WAIT_DEPTH    = pim_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS  = pim_pkg::TASK_ID_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = pim_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned IN_W          = 16,
  parameter int unsigned OUT_W         = 40
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire pim_pkg::pim_cmd_t              cmd_i,
  input  wire logic                           in_user_i,
  input  wire logic [IN_W-1:0]                in_data_i,
  output logic      [pim_pkg::STATUS_W-1:0]   out_user_o,
  output logic      [OUT_W-1:0]             out_data_o
);

  localparam int unsigned IB    = TASK_ID_BITS;
  localparam int unsigned PB    = PRIORITY_BITS;
  localparam int unsigned PTR_W = $clog2(WAIT_DEPTH);
  localparam int unsigned CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned ENT_W = IB + PB;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WAIT_DEPTH);

  logic            cmd_q;
  logic [IB-1:0]   id_q;
  logic [PB-1:0]   pri_q;
  logic            rdy_q;

  logic [IB-1:0]    owner_q, owner_d;
  logic [PB-1:0]    base_q, base_d;
  logic [PB-1:0]    live_q, live_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [pim_pkg::STATUS_W-1:0] status_q;
  logic [OUT_W-1:0]             data_q;

  logic [ENT_W-1:0] rd_ent;
  logic [IB-1:0]    head_id;
  logic [PB-1:0]    head_pri;
  logic             enq;

  pim_pkg::status_e st;
  logic          boost, move, requeue, sw;
  logic [IB-1:0] btask, nown;
  logic [PB-1:0] bpri, giver, npri;

  pim_ram #(
    .WIDTH(ENT_W),
    .DEPTH(WAIT_DEPTH)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (enq),
    .waddr_i(tail_q),
    .wdata_i({pri_q, id_q}),
    .re_i   (cmd_i.capture),
    .raddr_i(head_q),
    .rdata_o(rd_ent)
  );

  assign head_id  = rd_ent[IB-1:0];
  assign head_pri = rd_ent[IB +: PB];

  always_comb begin
    st      = pim_pkg::ST_IGNORED;
    boost   = 1'b0;
    btask   = '0;
    bpri    = '0;
    move    = 1'b0;
    giver   = '0;
    nown    = '0;
    npri    = '0;
    requeue = 1'b0;
    sw      = 1'b0;
    enq     = 1'b0;
    owner_d = owner_q;
    base_d  = base_q;
    live_d  = live_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (id_q != '0) begin
      if (cmd_q == pim_pkg::CMD_TAKE) begin
        if (owner_q == '0) begin
          owner_d = id_q;
          base_d  = pri_q;
          live_d  = pri_q;
          st      = pim_pkg::ST_GRANTED;
        end else if (owner_q == id_q) begin
          st = pim_pkg::ST_ALREADY;
        end else if (count_q >= FULL_CNT) begin
          st = pim_pkg::ST_WAIT_FULL;
        end else begin
          if (pri_q < live_q) begin
            live_d = pri_q;
            boost  = 1'b1;
            btask  = owner_q;
            bpri   = pri_q;
            move   = rdy_q;
          end
          enq     = cmd_i.commit;
          tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
          count_d = count_q + CNT_W'(1);
          st      = pim_pkg::ST_BLOCKED;
          sw      = 1'b1;
        end
      end else if (owner_q == id_q) begin
        giver = base_q;
        if (count_q != '0) begin
          head_d  = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
          count_d = count_q - CNT_W'(1);
          owner_d = head_id;
          base_d  = head_pri;
          live_d  = head_pri;
          st      = pim_pkg::ST_HANDOVER;
          nown    = head_id;
          npri    = head_pri;
          if (head_pri < base_q) begin
            requeue = 1'b1;
            sw      = 1'b1;
          end
        end else begin
          owner_d = '0;
          st      = pim_pkg::ST_FREED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      base_q  <= '0;
      live_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      owner_q <= owner_d;
      base_q  <= base_d;
      live_q  <= live_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_user_i;
      id_q  <= in_data_i[IB-1:0];
      pri_q <= in_data_i[IB +: PB];
      rdy_q <= in_data_i[IB + PB];
    end
    if (cmd_i.commit) begin
      status_q <= st;
      data_q   <= OUT_W'({sw, requeue, npri, nown, giver, move, bpri, btask, boost});
    end
  end

  assign out_user_o = status_q;
  assign out_data_o = data_q;

  // Waiters are only queued behind a live owner, so a free lock has no waiters.
  a_free_no_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (owner_q == '0) |-> (count_q == '0))
    else $error("free lock with queued waiters");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("waiter count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with unequal pointers");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("enqueue did not advance the count");

endmodule
`default_nettype wire

// ===== hdl/pim_ctrl.sv =====
`default_nettype none
module pim_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pim_pkg::pim_cmd_t      cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit;
  logic   capture;

  assign capture = (state_q == S_IDLE) && in_valid_i;
  assign commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (capture) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule
`default_nettype wire
